// ----- sv/hmf_pkg.sv -----
// shared types, constants and helper functions of the http message framer
package hmf_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int LEN_WIDTH   = 31;
    localparam int PHASE_WIDTH = 5;
    localparam int DIFF_WIDTH  = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
    localparam int ACC_WIDTH   = LEN_WIDTH + 4;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LEN_WIDTH-1:0]   len_t;
    typedef logic [PHASE_WIDTH-1:0] phase_t;

    localparam count_t CNT_MAX = '1;
    localparam len_t   LEN_MAX = '1;

    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_VT    = 8'h0B;
    localparam logic [7:0]  CHAR_FF    = 8'h0C;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [23:0] HDR_END_TAIL = {CHAR_CR, CHAR_LF, CHAR_CR};

    // line match phases: 0 to 14 walk the prefix
    localparam phase_t PH_START = 5'd0;
    localparam phase_t PH_WS    = 5'd15;
    localparam phase_t PH_PSIGN = 5'd16;
    localparam phase_t PH_PDIG  = 5'd17;
    localparam phase_t PH_FAIL  = 5'd18;
    localparam phase_t PH_NSIGN = 5'd19;
    localparam phase_t PH_NDIG  = 5'd20;
    localparam phase_t PH_PEND  = 5'd21;
    localparam phase_t PH_NEND  = 5'd22;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } byte_beat_t;

    typedef struct packed {
        logic        message_done;
        logic        header_done;
        logic        length_present;
        logic [30:0] body_length;
        logic [31:0] header_byte_count;
        logic [31:0] received_count;
    } status_beat_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) ||
               (b == CHAR_FF) || (b == CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // acc * 10 + digit, saturated
    function automatic len_t acc_digit(input len_t acc, input logic [7:0] b);
        logic [7:0]           d8;
        logic [ACC_WIDTH-1:0] v;
        d8 = b - CHAR_ZERO;
        v  = (ACC_WIDTH'(acc) << 3) + (ACC_WIDTH'(acc) << 1) + ACC_WIDTH'(d8[3:0]);
        return (v > ACC_WIDTH'(LEN_MAX)) ? LEN_MAX : v[LEN_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] low_word(input count_t c);
        logic [63:0] w;
        w = 64'(c);
        return w[31:0];
    endfunction

endpackage

// ----- sv/hmf_byte_if.sv -----
// handshake channel carrying received bytes and the stream end flag
interface hmf_byte_if;
    import hmf_pkg::*;

    logic       valid;
    logic       ready;
    byte_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/hmf_status_if.sv -----
// handshake channel carrying the framing status after each byte
interface hmf_status_if;
    import hmf_pkg::*;

    logic         valid;
    logic         ready;
    status_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/http_message_framer.sv -----
// http message framer top level
// Takes one beat per cycle on byte_chan while status_chan is ready and returns one status
// beat for each in the next cycle; a new byte is taken in the same cycle the previous
// status leaves, so the block sustains one byte per clock unless stalled. The status is
// kept in the state registers that hold the match phase, the length accumulator and the
// counters, which double as the status output register. Header lines are matched against
// Content-Length while the header is open; the message ends at the blank line without a
// length, after the given number of body bytes with one, or at stream end. After that
// every beat repeats the final status.
module http_message_framer (
    input  logic         clk,
    input  logic         rst_n,
    hmf_byte_if.sink     byte_chan,
    hmf_status_if.source status_chan
);
    import hmf_pkg::*;

    logic        valid_reg;
    logic        finished_reg, finished_next;
    logic        len_seen_reg, len_seen_next;
    len_t        len_val_reg, len_val_next;
    len_t        acc_reg, acc_next;
    phase_t      phase_reg, phase_next;
    logic [23:0] recent_reg, recent_next;
    count_t      rcv_reg, rcv_next;
    count_t      hdr_reg, hdr_next;

    logic                  accept;
    logic [7:0]            b;
    logic [DIFF_WIDTH-1:0] body_seen;

    assign byte_chan.ready = !valid_reg || status_chan.ready;
    assign accept          = byte_chan.valid && byte_chan.ready;
    assign b               = byte_chan.data.data_byte;
    assign body_seen       = DIFF_WIDTH'(rcv_next - hdr_next);

    always_comb
    begin
        finished_next = finished_reg;
        len_seen_next = len_seen_reg;
        len_val_next  = len_val_reg;
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        recent_next   = recent_reg;
        rcv_next      = rcv_reg;
        hdr_next      = hdr_reg;
        if (accept && !finished_reg)
        begin
            if (byte_chan.data.stream_end)
            begin
                finished_next = 1'b1;
            end
            else
            begin
                rcv_next    = (rcv_reg != CNT_MAX) ? rcv_reg + 1'b1 : rcv_reg;
                recent_next = {recent_reg[15:0], b};
                if (hdr_reg == '0)
                begin
                    if (b == CHAR_LF)
                    begin
                        if (recent_reg == HDR_END_TAIL)
                        begin
                            hdr_next = rcv_next;
                            if (!len_seen_reg)
                            begin
                                finished_next = 1'b1;
                            end
                        end
                        else if ((phase_reg == PH_PDIG) || (phase_reg == PH_PEND))
                        begin
                            len_seen_next = 1'b1;
                            len_val_next  = acc_reg;
                        end
                        else if ((phase_reg == PH_NDIG) || (phase_reg == PH_NEND))
                        begin
                            len_seen_next = 1'b1;
                            len_val_next  = '0;
                        end
                        phase_next = PH_START;
                        acc_next   = '0;
                    end
                    else if (phase_reg < PH_WS)
                    begin
                        phase_next = (b == prefix_char(phase_reg[3:0])) ?
                                     phase_reg + 1'b1 : PH_FAIL;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_WS:
                            begin
                                priority if (is_space(b))
                                begin
                                    phase_next = PH_WS;
                                end
                                else if (b == CHAR_PLUS)
                                begin
                                    phase_next = PH_PSIGN;
                                end
                                else if (b == CHAR_MINUS)
                                begin
                                    phase_next = PH_NSIGN;
                                end
                                else if (is_digit(b))
                                begin
                                    acc_next   = acc_digit('0, b);
                                    phase_next = PH_PDIG;
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_PSIGN, PH_NSIGN:
                            begin
                                if (is_digit(b))
                                begin
                                    acc_next   = acc_digit('0, b);
                                    phase_next = (phase_reg == PH_PSIGN) ? PH_PDIG : PH_NDIG;
                                end
                                else
                                begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_PDIG, PH_NDIG:
                            begin
                                if (is_digit(b))
                                begin
                                    acc_next = acc_digit(acc_reg, b);
                                end
                                else
                                begin
                                    phase_next = (phase_reg == PH_PDIG) ? PH_PEND : PH_NEND;
                                end
                            end
                            PH_PEND, PH_NEND:
                            begin
                                phase_next = phase_reg;
                            end
                            default:
                            begin
                                phase_next = PH_FAIL;
                            end
                        endcase
                    end
                end
                // body complete
                if (!finished_next && (hdr_next != '0) && len_seen_next &&
                    (body_seen == DIFF_WIDTH'(len_val_next)))
                begin
                    finished_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            finished_reg <= 1'b0;
            len_seen_reg <= 1'b0;
            len_val_reg  <= '0;
            acc_reg      <= '0;
            phase_reg    <= PH_START;
            recent_reg   <= '0;
            rcv_reg      <= '0;
            hdr_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (status_chan.ready)
            begin
                valid_reg <= 1'b0;
            end
            finished_reg <= finished_next;
            len_seen_reg <= len_seen_next;
            len_val_reg  <= len_val_next;
            acc_reg      <= acc_next;
            phase_reg    <= phase_next;
            recent_reg   <= recent_next;
            rcv_reg      <= rcv_next;
            hdr_reg      <= hdr_next;
        end
    end

    assign status_chan.valid                  = valid_reg;
    assign status_chan.data.message_done      = finished_reg;
    assign status_chan.data.header_done       = (hdr_reg != '0);
    assign status_chan.data.length_present    = len_seen_reg;
    assign status_chan.data.body_length       = len_val_reg;
    assign status_chan.data.header_byte_count = low_word(hdr_reg);
    assign status_chan.data.received_count    = low_word(rcv_reg);

endmodule

// ----- sv/hmf_checker.sv -----
// port level checks of the http message framer and their binding
module hmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        message_done,
    input logic        header_done,
    input logic [31:0] header_byte_count,
    input logic [31:0] received_count
);

    logic done_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && message_done)
        begin
            done_seen_reg <= 1'b1;
        end
    end

    // stalled status beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(received_count) &&
        $stable(message_done))
        else $error("status beat changed while stalled");

    // every byte beat yields a status beat in the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no status beat after accepted byte");

    // an empty status slot never blocks the byte channel
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte channel stalled with empty status slot");

    // once done, the message stays done
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_seen_reg |-> message_done)
        else $error("message done dropped");

    // no header byte count before the header end
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_done |-> header_byte_count == 32'd0)
        else $error("header byte count set before header end");

endmodule

bind http_message_framer hmf_checker u_hmf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (byte_chan.valid),
    .in_ready          (byte_chan.ready),
    .out_valid         (status_chan.valid),
    .out_ready         (status_chan.ready),
    .message_done      (status_chan.data.message_done),
    .header_done       (status_chan.data.header_done),
    .header_byte_count (status_chan.data.header_byte_count),
    .received_count    (status_chan.data.received_count)
);

// ----- verif/tb_top.sv -----
// testbench for the http message framer with random handshake gaps, checked beat by beat
module tb_top;
    import hmf_pkg::*;

    localparam string CL_PREFIX = "Content-Length:";

    class framer_scoreboard;
        count_t       rx_total;
        logic [23:0]  last_three;
        phase_t       phase;
        len_t         accum;
        len_t         cl_value;
        bit           cl_seen;
        count_t       hdr_count;
        bit           done;
        status_beat_t pending[$];
        int           errors;
        int           checked;

        function new();
            rx_total   = '0;
            last_three = '0;
            phase      = PH_START;
            accum      = '0;
            cl_value   = '0;
            cl_seen    = 1'b0;
            hdr_count  = '0;
            done       = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void report_mismatch(string what);
            $display("status mismatch: %s", what);
            errors++;
        endfunction

        function len_t next_decimal(len_t acc, logic [7:0] b);
            logic [35:0] v;
            v = 36'(acc) * 36'd10 + 36'(b - CHAR_ZERO);
            return (v > 36'(LEN_MAX)) ? LEN_MAX : v[LEN_WIDTH-1:0];
        endfunction

        function void scan_byte(logic [7:0] b);
            bit digit;
            bit space;
            digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            space = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) ||
                    (b == CHAR_FF) || (b == CHAR_CR);
            if (phase < PH_WS)
                phase = (b == CL_PREFIX[phase]) ? phase + 5'd1 : PH_FAIL;
            else if (phase == PH_WS)
            begin
                if (space)
                    phase = PH_WS;
                else if (b == CHAR_PLUS)
                    phase = PH_PSIGN;
                else if (b == CHAR_MINUS)
                    phase = PH_NSIGN;
                else if (digit)
                begin
                    accum = next_decimal('0, b);
                    phase = PH_PDIG;
                end
                else
                    phase = PH_FAIL;
            end
            else if (phase == PH_PSIGN || phase == PH_NSIGN)
            begin
                if (digit)
                begin
                    accum = next_decimal('0, b);
                    phase = (phase == PH_PSIGN) ? PH_PDIG : PH_NDIG;
                end
                else
                    phase = PH_FAIL;
            end
            else if (phase == PH_PDIG || phase == PH_NDIG)
            begin
                if (digit)
                    accum = next_decimal(accum, b);
                else
                    phase = (phase == PH_PDIG) ? PH_PEND : PH_NEND;
            end
            else if (phase != PH_PEND && phase != PH_NEND)
                phase = PH_FAIL;
        endfunction

        function void take_byte(logic [7:0] b);
            if (rx_total != CNT_MAX)
                rx_total++;
            if (hdr_count == '0)
            begin
                if (b == CHAR_LF)
                begin
                    if (last_three == HDR_END_TAIL)
                    begin
                        hdr_count = rx_total;
                        if (!cl_seen)
                            done = 1'b1;
                    end
                    else if (phase == PH_PDIG || phase == PH_PEND)
                    begin
                        cl_seen  = 1'b1;
                        cl_value = accum;
                    end
                    else if (phase == PH_NDIG || phase == PH_NEND)
                    begin
                        cl_seen  = 1'b1;
                        cl_value = '0;
                    end
                    phase = PH_START;
                    accum = '0;
                end
                else
                    scan_byte(b);
            end
            last_three = {last_three[15:0], b};
            if (!done && hdr_count != '0 && cl_seen &&
                (rx_total - hdr_count) == count_t'(cl_value))
                done = 1'b1;
        endfunction

        function void note_byte(byte_beat_t beat);
            status_beat_t want;
            if (!done)
            begin
                if (beat.stream_end)
                    done = 1'b1;
                else
                    take_byte(beat.data_byte);
            end
            want.message_done      = done;
            want.header_done       = (hdr_count != '0);
            want.length_present    = cl_seen;
            want.body_length       = cl_value;
            want.header_byte_count = hdr_count;
            want.received_count    = rx_total;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                          checked, name, got, want));
        endfunction

        function void check_status(status_beat_t got);
            status_beat_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("beat %0d arrived with no byte pending", checked));
                checked++;
                return;
            end
            want = pending.pop_front();
            compare_field("message_done", 32'(got.message_done), 32'(want.message_done));
            compare_field("header_done", 32'(got.header_done), 32'(want.header_done));
            compare_field("length_present", 32'(got.length_present), 32'(want.length_present));
            compare_field("body_length", 32'(got.body_length), 32'(want.body_length));
            compare_field("header_byte_count", got.header_byte_count, want.header_byte_count);
            compare_field("received_count", got.received_count, want.received_count);
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    hmf_byte_if   byte_chan ();
    hmf_status_if status_chan ();

    http_message_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .status_chan (status_chan)
    );

    framer_scoreboard sb = new();
    byte_beat_t       byte_plan[$];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_chan.valid && byte_chan.ready)
                sb.note_byte(byte_chan.data);
            if (status_chan.valid && status_chan.ready)
                sb.check_status(status_chan.data);
        end
    end

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_LF)
            b = 8'h00;
        return b;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        byte_beat_t beat;
        beat.data_byte  = b;
        beat.stream_end = 1'b0;
        byte_plan.push_back(beat);
    endfunction

    function automatic void push_end();
        byte_beat_t beat;
        beat.data_byte  = 8'($urandom_range(0, 255));
        beat.stream_end = 1'b1;
        byte_plan.push_back(beat);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_crlf();
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
    endfunction

    // one header line; without allow_len no line can capture a length
    function automatic void gen_header_line(bit allow_len);
        int         kind;
        int         k;
        int         ndig;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            repeat ($urandom_range(1, 40)) push_byte(rand_text_byte());
        else if (kind == 3)
        begin
            k = $urandom_range(1, 14);
            for (int i = 0; i < k; i++)
                push_byte(CL_PREFIX[i]);
            b = rand_text_byte();
            if (b == CL_PREFIX[k])
                b = b ^ 8'h01;
            push_byte(b);
            repeat ($urandom_range(0, 5)) push_byte(rand_text_byte());
        end
        else if (kind == 4)
        begin
            push_byte(rand_text_byte());
            push_text(CL_PREFIX);
            push_text(" 42");
        end
        else
        begin
            push_text(CL_PREFIX);
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 4))
                    0: push_byte(CHAR_SPACE);
                    1: push_byte(CHAR_TAB);
                    2: push_byte(CHAR_VT);
                    3: push_byte(CHAR_FF);
                    default: push_byte(CHAR_CR);
                endcase
            end
            case ($urandom_range(0, 5))
                4: push_byte(CHAR_PLUS);
                5: push_byte(CHAR_MINUS);
                default: ;
            endcase
            if (allow_len)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_byte(rand_text_byte());
                ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
                repeat (ndig) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 6)) push_byte(rand_text_byte());
            end
        end
        push_crlf();
    endfunction

    task automatic send_beat(byte_beat_t beat, int gap);
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid <= 1'b1;
        byte_chan.data  <= beat;
        do
            @(posedge clk);
        while (!byte_chan.ready);
    endtask

    task automatic wait_drained();
        byte_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    initial
    begin
        int stall;
        status_chan.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                status_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            status_chan.ready <= 1'b1;
            do
                @(posedge clk);
            while (!status_chan.valid);
        end
    end

    initial
    begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int scenario;
        int header_target;
        int body_len;
        int drain_idx;
        rst_n           = 1'b0;
        byte_chan.valid = 1'b0;
        byte_chan.data  = '0;

        // 0: no length, 1: empty body, 2: full body, 3: close in body, 4: close in header
        scenario      = $urandom_range(0, 4);
        header_target = $urandom_range(1300, 1420);
        body_len      = $urandom_range(1, 250);

        if (scenario == 0)
            push_text("content-Length:7");
        else
        begin
            push_text(CL_PREFIX);
            push_byte(CHAR_TAB);
            push_text("+9999999999");
        end
        push_crlf();
        while (byte_plan.size() < header_target)
            gen_header_line(scenario != 0);

        if (scenario == 1)
        begin
            push_text(CL_PREFIX);
            push_byte(CHAR_SPACE);
            if ($urandom_range(0, 1) == 0)
                push_byte(CHAR_ZERO);
            else
            begin
                push_byte(CHAR_MINUS);
                repeat ($urandom_range(1, 3)) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            push_crlf();
        end
        else if (scenario == 2 || scenario == 3)
        begin
            push_text(CL_PREFIX);
            push_text($sformatf(" %0d", body_len));
            push_crlf();
        end

        drain_idx = byte_plan.size();
        if (scenario == 4)
            push_end();
        else
            push_crlf();

        if (scenario == 2)
            repeat (body_len) push_byte(8'($urandom_range(0, 255)));
        else if (scenario == 3)
        begin
            repeat ($urandom_range(0, body_len - 1)) push_byte(8'($urandom_range(0, 255)));
            push_end();
        end

        // beats after the end of the message
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                push_end();
            else
                push_byte(8'($urandom_range(0, 255)));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < byte_plan.size(); i++)
        begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == drain_idx || $urandom_range(0, 299) == 0)
                wait_drained();
            send_beat(byte_plan[i], calm ? 0 : $urandom_range(0, 6));
        end
        byte_chan.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hmf_pkg.sv
sv/hmf_byte_if.sv
sv/hmf_status_if.sv
sv/http_message_framer.sv
sv/hmf_checker.sv
verif/tb_top.sv
